FILE: design/segment_tree_count_sum_macros.svh
// ============================================================================
// segment_tree_count_sum_macros.svh
// Assertion macros for the segment tree count/sum top-level design file.
// ============================================================================
`ifndef SEGMENT_TREE_COUNT_SUM_MACROS_SVH
`define SEGMENT_TREE_COUNT_SUM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/stcs_pkg.sv
// ============================================================================
// stcs_pkg
// Field widths, operation codes and the controller/datapath interface types
// of the segment tree count/sum block.
// ============================================================================
package stcs_pkg;

    // Fixed widths of the stream fields.
    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 17;
    localparam int END_W      = 18;
    localparam int COUNT_W    = 20;
    localparam int TOTAL_W    = 48;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;
    localparam int IN_PAD_W   = IN_DATA_W - INDEX_W - END_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - COUNT_W - TOTAL_W;

    // Operation codes carried in the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FN_RANGE  = 2'd0,
        FN_INSERT = 2'd1,
        FN_SUFFIX = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch a new word and set up the walk
        logic rd_lo;      // read node lo, then step lo up
        logic rd_hi;      // step hi down, then read node hi
        logic rd_k;       // read node k of the insert path
        logic acc_add;    // add read data into the range accumulator
        logic lvl_shift;  // move lo and hi one level up
        logic wr_k;       // write back node k plus one, move k up
        logic tot_add;    // add the range count into the running total
        logic clr_wr;     // zero one node of the clearing sweep
        logic out_load;   // capture the result word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lo_lt_hi;
        logic lo_odd;
        logic hi_odd;
        logic k_zero;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

FILE: design/stcs_ctrl.sv
// ============================================================================
// stcs_ctrl
// Sequencer for the segment tree: walks the range count one node read at a
// time, walks the insert path with read/write pairs, and drives the sweep
// that clears the node memory.
// ============================================================================
module stcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  stcs_pkg::t_func  i_in_func,
    output logic             o_in_ready,
    output stcs_pkg::t_cmd   o_cmd,
    input  stcs_pkg::t_sts   i_sts
);
    import stcs_pkg::*;

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_LVL,
        S_LO_ACC,
        S_HI_CHK,
        S_HI_ACC,
        S_TOT,
        S_INS_RD,
        S_INS_WR,
        S_OP_CLR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_func  r_func,  n_func;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        o_cmd   = '0;
        case (r_state)
            S_RST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_func     = i_in_func;
                    case (i_in_func)
                        FN_RANGE:  n_state = S_LVL;
                        FN_SUFFIX: n_state = S_LVL;
                        FN_INSERT: n_state = S_INS_RD;
                        FN_CLEAR:  n_state = S_OP_CLR;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LVL: begin
                if (!i_sts.lo_lt_hi) begin
                    n_state = (r_func == FN_SUFFIX) ? S_TOT : S_DONE;
                end else if (i_sts.lo_odd) begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_LO_ACC;
                end else if (i_sts.hi_odd) begin
                    o_cmd.rd_hi = 1'b1;
                    n_state     = S_HI_ACC;
                end else begin
                    o_cmd.lvl_shift = 1'b1;
                end
            end
            S_LO_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_HI_CHK;
            end
            S_HI_CHK: begin
                if (i_sts.hi_odd) begin
                    o_cmd.rd_hi = 1'b1;
                    n_state     = S_HI_ACC;
                end else begin
                    o_cmd.lvl_shift = 1'b1;
                    n_state         = S_LVL;
                end
            end
            S_HI_ACC: begin
                o_cmd.acc_add   = 1'b1;
                o_cmd.lvl_shift = 1'b1;
                n_state         = S_LVL;
            end
            S_TOT: begin
                o_cmd.tot_add = 1'b1;
                n_state       = S_INS_RD;
            end
            S_INS_RD: begin
                if (i_sts.k_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_k = 1'b1;
                    n_state    = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_k = 1'b1;
                n_state    = S_INS_RD;
            end
            S_OP_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
            r_func  <= FN_RANGE;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: design/stcs_datapath.sv
// ============================================================================
// stcs_datapath
// Node memory, walk pointers, saturating accumulators and the result
// register of the segment tree.
// ============================================================================
module stcs_datapath #(
    parameter int LEAF_BITS  = 17,
    parameter int COUNT_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stcs_pkg::t_cmd                i_cmd,
    output stcs_pkg::t_sts                o_sts,
    input  stcs_pkg::t_func               i_in_func,
    input  logic [stcs_pkg::INDEX_W-1:0]  i_index,
    input  logic [stcs_pkg::END_W-1:0]    i_range_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [stcs_pkg::COUNT_W-1:0]  o_count,
    output logic [stcs_pkg::TOTAL_W-1:0]  o_total
);
    import stcs_pkg::*;

    // Node address, walk pointer and clamp widths.
    localparam int AW = LEAF_BITS + 1;
    localparam int PW = LEAF_BITS + 2;
    localparam int CW = (END_W > PW) ? END_W : PW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] LEAVES_C = CW'(1) << LEAF_BITS;
    localparam logic [PW-1:0] LEAVES_P = PW'(1) << LEAF_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;

    logic [PW-1:0]         r_lo;
    logic [PW-1:0]         r_hi;
    logic [AW-1:0]         r_k;
    logic [COUNT_BITS-1:0] r_acc;
    logic [TOTAL_W-1:0]    r_total;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_out_count;
    logic [TOTAL_W-1:0]    r_out_total;

    logic [LEAF_BITS-1:0]  idx;
    logic [CW-1:0]         end_c;
    logic [CW-1:0]         hi_base;
    logic [PW-1:0]         hi_dec;
    logic [COUNT_BITS:0]   acc_sum;
    logic [COUNT_BITS-1:0] node_inc;
    logic [TOTAL_W:0]      tot_sum;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // Set-up of the walk: leaf index and the clamped exclusive end (all leaves for a suffix).
    always_comb begin
        idx   = LEAF_BITS'(i_index);
        end_c = CW'(i_range_end);
        if ((i_in_func == FN_SUFFIX) || (end_c > LEAVES_C)) begin
            hi_base = LEAVES_C;
        end else begin
            hi_base = end_c;
        end
    end

    // Saturating adders and the node increment.
    always_comb begin
        hi_dec   = r_hi - PW'(1);
        acc_sum  = {1'b0, r_acc} + {1'b0, r_rdata};
        node_inc = (&r_rdata) ? r_rdata : r_rdata + COUNT_BITS'(1);
        tot_sum  = {1'b0, r_total} + (TOTAL_W + 1)'(r_acc);
    end

    // Memory port selection.
    always_comb begin
        mem_re    = i_cmd.rd_lo | i_cmd.rd_hi | i_cmd.rd_k;
        mem_raddr = r_k;
        if (i_cmd.rd_lo) begin
            mem_raddr = r_lo[AW-1:0];
        end else if (i_cmd.rd_hi) begin
            mem_raddr = hi_dec[AW-1:0];
        end
        mem_we    = i_cmd.wr_k | i_cmd.clr_wr;
        mem_waddr = i_cmd.clr_wr ? r_clr_addr : r_k;
        mem_wdata = i_cmd.clr_wr ? '0 : node_inc;
    end

    // Node memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Walk pointers, accumulator and running total.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo  <= PW'(idx) + LEAVES_P;
            r_hi  <= PW'(hi_base) + LEAVES_P;
            r_k   <= {1'b1, idx};
            r_acc <= '0;
        end else begin
            if (i_cmd.rd_lo) begin
                r_lo <= r_lo + PW'(1);
            end else if (i_cmd.lvl_shift) begin
                r_lo <= r_lo >> 1;
            end
            if (i_cmd.rd_hi) begin
                r_hi <= hi_dec;
            end else if (i_cmd.lvl_shift) begin
                r_hi <= r_hi >> 1;
            end
            if (i_cmd.acc_add) begin
                r_acc <= acc_sum[COUNT_BITS] ? '1 : acc_sum[COUNT_BITS-1:0];
            end
            if (i_cmd.wr_k) begin
                r_k <= r_k >> 1;
            end
        end
        if (i_cmd.clr_wr) begin
            r_total <= '0;
        end else if (i_cmd.tot_add) begin
            r_total <= tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
        end
    end

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.load) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Result register; it holds one word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= COUNT_W'(r_acc);
            r_out_total <= r_total;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_sts.lo_lt_hi = (r_lo < r_hi);
        o_sts.lo_odd   = r_lo[0];
        o_sts.hi_odd   = r_hi[0];
        o_sts.k_zero   = (r_k == '0);
        o_sts.clr_last = &r_clr_addr;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_count     = r_out_count;
    assign o_total     = r_out_total;

endmodule

FILE: design/segment_tree_count_sum.sv
// Range count: at each of up to LEAF_BITS + 1 tree levels, reads node lo and/or node hi.
// Insert: each node on the leaf-to-root path is read, then written back plus one.
// Count-and-insert: both walks with the total update between them; clear zeros every node.
// Every node access goes through the single node memory, whose read data is registered.
// One word at a time: input ready returns in the cycle after the result loads.
// Reset starts a sweep that zeros every node of the node memory.
// ============================================================================
// segment_tree_count_sum
// Segment tree of occurrence counts with range count, insert, combined
// count-at-or-above with running total, and clear. One result per word.
// ============================================================================
`include "segment_tree_count_sum_macros.svh"

module segment_tree_count_sum #(
    parameter int LEAF_BITS  = 17,
    parameter int COUNT_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [16:0] index, [34:17] range_end, [39:35] zero
    input  logic [stcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] func
    input  logic [stcs_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [19:0] count, [67:20] running_total, [71:68] zero
    output logic [stcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import stcs_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    t_func              in_func;
    logic [COUNT_W-1:0] out_count;
    logic [TOTAL_W-1:0] out_total;

    assign in_func = t_func'(s_axis_tuser);

    // Sequencer.
    stcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (in_func),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Memory and arithmetic.
    stcs_datapath #(
        .LEAF_BITS  (LEAF_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_func   (in_func),
        .i_index     (s_axis_tdata[INDEX_W-1:0]),
        .i_range_end (s_axis_tdata[INDEX_W+END_W-1:INDEX_W]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_count     (out_count),
        .o_total     (out_total)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_total, out_count};

    // An accepted word keeps the block busy for at least the next cycle.
    `STCS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted word")

    // A result is captured only when the output register is free.
    `STCS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwrote a pending output word")

    // The node memory never reads and writes in the same cycle.
    `STCS_ASSERT_NOW(a_mem_one_access, i_clk, i_rst_n, cmd.rd_lo || cmd.rd_hi || cmd.rd_k, !(cmd.wr_k || cmd.clr_wr), "node memory read and written in one cycle")

endmodule

FILE: test/tb_segment_tree_count_sum.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_segment_tree_count_sum
// Self-checking bench for the segment tree count/sum block. Words go in and
// out over the two stream ports while both sides pause at random. A local
// copy of the count tree and the running total predicts every result word,
// and each result is compared field by field with the oldest prediction.
// ============================================================================
module tb_segment_tree_count_sum;
    import stcs_pkg::*;

    localparam int     LEAF_BITS   = 17;
    localparam int     COUNT_BITS  = 20;
    localparam int     NUM_LEAVES  = 1 << LEAF_BITS;
    localparam int     NUM_NODES   = 1 << (LEAF_BITS + 1);
    localparam longint COUNT_MAX   = (64'd1 << COUNT_BITS) - 1;
    localparam longint TOTAL_MAX   = (64'd1 << TOTAL_W) - 1;
    localparam longint END_MAX     = (64'd1 << END_W) - 1;
    localparam int     MAX_GAP     = 18;
    localparam int     TAIL_CYCLES = 400;
    localparam int     PRINT_CAP   = 40;
    // A clear walks every node, and so does the sweep after reset.
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct {
        bit [COUNT_W-1:0] count;
        bit [TOTAL_W-1:0] total;
    } tree_result_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]     s_axis_tuser  = FN_RANGE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Local copy of the tree and the total.
    bit [COUNT_BITS-1:0] tree_cnt [0:NUM_NODES-1];
    longint              run_total = 0;
    tree_result_t        pending_results [$];

    int     err_cnt    = 0;
    int     result_cnt = 0;
    int     tx_quiet   = 0;
    int     rx_quiet   = 0;
    longint cycle_cnt  = 0;

    segment_tree_count_sum #(
        .LEAF_BITS  (LEAF_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    // Wait before one word; now and then a stretch with no waiting at all.
    function automatic int draw_gap(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Count of items with position in [lo, hi), saturating per level.
    function automatic longint count_range(longint lo, longint hi);
        longint acc = 0;
        if (hi > NUM_LEAVES)
            hi = NUM_LEAVES;
        if (lo >= hi)
            return 0;
        lo += NUM_LEAVES;
        hi += NUM_LEAVES;
        while (lo < hi) begin
            if (lo & 1) begin
                acc += tree_cnt[lo];
                lo++;
            end
            if (hi & 1) begin
                hi--;
                acc += tree_cnt[hi];
            end
            if (acc > COUNT_MAX)
                acc = COUNT_MAX;
            lo = lo >> 1;
            hi = hi >> 1;
        end
        return acc;
    endfunction

    // Raise every node on the path from one leaf to the root.
    function automatic void insert_leaf(longint pos);
        longint k;
        k = (pos & (NUM_LEAVES - 1)) + NUM_LEAVES;
        while (k > 0) begin
            if (tree_cnt[k] < COUNT_MAX)
                tree_cnt[k] = tree_cnt[k] + 1'b1;
            k = k >> 1;
        end
    endfunction

    // Apply one accepted word to the local tree and queue its result.
    function automatic void apply_tree_word(t_func fn, bit [INDEX_W-1:0] idx,
                                            bit [END_W-1:0] rend);
        tree_result_t r;
        longint       cnt;
        cnt = 0;
        case (fn)
            FN_RANGE: begin
                cnt = count_range(idx, rend);
            end
            FN_INSERT: begin
                insert_leaf(idx);
            end
            FN_SUFFIX: begin
                cnt = count_range(idx, NUM_LEAVES);
                if (TOTAL_MAX - run_total < cnt)
                    run_total = TOTAL_MAX;
                else
                    run_total += cnt;
                insert_leaf(idx);
            end
            default: begin
                foreach (tree_cnt[i])
                    tree_cnt[i] = '0;
                run_total = 0;
            end
        endcase
        r.count = cnt[COUNT_W-1:0];
        r.total = run_total[TOTAL_W-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (err_cnt < PRINT_CAP)
            $display("mismatch in result %0d, %s: got %0h, want %0h",
                     result_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic check_result(logic [OUT_DATA_W-1:0] word);
        tree_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", word[COUNT_W-1:0], '0);
        end else begin
            want = pending_results.pop_front();
            if (word[COUNT_W-1:0] !== want.count)
                report_mismatch("count", word[COUNT_W-1:0], want.count);
            if (word[COUNT_W +: TOTAL_W] !== want.total)
                report_mismatch("running_total", word[COUNT_W +: TOTAL_W], want.total);
        end
        result_cnt++;
    endtask

    // Result side: take each word, then hold ready low for a random stall.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                stall = draw_gap(rx_quiet);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Present one word after a random gap and hold it until it is taken.
    // Valid stays high after acceptance so back-to-back words need one update.
    task automatic send_word(t_func fn, bit [INDEX_W-1:0] idx, bit [END_W-1:0] rend);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, rend, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_tree_word(fn, idx, rend);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Edge leaves, clamped, empty and reversed ranges, every operation.
    task automatic test_directed_edges();
        send_word(FN_RANGE,  17'd0,      18'd131072);
        send_word(FN_INSERT, 17'd0,      18'h3FFFF);
        send_word(FN_INSERT, 17'd0,      18'd0);
        send_word(FN_INSERT, 17'h1FFFF,  18'h2AAAA);
        send_word(FN_INSERT, 17'd65536,  18'd7);
        send_word(FN_RANGE,  17'd0,      18'd1);
        send_word(FN_RANGE,  17'd0,      18'd131072);
        send_word(FN_RANGE,  17'h1FFFF,  18'd131072);
        send_word(FN_RANGE,  17'd1,      18'h3FFFF);
        send_word(FN_RANGE,  17'h1FFFF,  18'h1FFFF);
        send_word(FN_RANGE,  17'd100,    18'd5);
        send_word(FN_RANGE,  17'h0AAAA,  18'h2AAAA);
        send_word(FN_INSERT, 17'h15555,  18'h15555);
        send_word(FN_SUFFIX, 17'h15555,  18'h0);
        send_word(FN_SUFFIX, 17'd0,      18'h3FFFF);
        send_word(FN_SUFFIX, 17'h1FFFF,  18'd131072);
        send_word(FN_RANGE,  17'd0,      18'd0);
        send_word(FN_CLEAR,  17'h1FFFF,  18'h3FFFF);
        send_word(FN_RANGE,  17'd0,      18'd131072);
        send_word(FN_SUFFIX, 17'd0,      18'd0);
        send_word(FN_INSERT, 17'h1FFFF,  18'd0);
        send_word(FN_RANGE,  17'h1FFFF,  18'h3FFFF);
    endtask

    // Inserts, counts and combined steps, clustered in windows of varying
    // width so that counts grow well beyond one.
    task automatic test_random_mix(int n_items);
        int               win_size;
        int               win_base;
        int               pick;
        longint           rend_val;
        bit [INDEX_W-1:0] idx;
        t_func            fn;
        win_size = 4;
        win_base = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 90 == 0) begin
                case ($urandom_range(0, 3))
                    0: win_size = 4;
                    1: win_size = 64;
                    2: win_size = 4096;
                    default: win_size = NUM_LEAVES;
                endcase
                win_base = $urandom_range(0, NUM_LEAVES - 1);
            end
            if (i == n_items / 2)
                wait_results_drained();

            pick = $urandom_range(0, 99);
            if (pick < 3)
                idx = '0;
            else if (pick < 6)
                idx = '1;
            else
                idx = INDEX_W'(win_base + $urandom_range(0, win_size - 1));

            pick = $urandom_range(0, 99);
            if (pick < 25)
                fn = FN_RANGE;
            else if (pick < 60)
                fn = FN_INSERT;
            else
                fn = FN_SUFFIX;

            pick = $urandom_range(0, 99);
            if (pick < 55)
                rend_val = longint'(idx) + $urandom_range(0, 2 * win_size);
            else if (pick < 70)
                rend_val = $urandom_range(0, int'(END_MAX));
            else if (pick < 80)
                rend_val = NUM_LEAVES;
            else if (pick < 92)
                rend_val = $urandom_range(0, int'(idx));
            else
                rend_val = idx;
            if (rend_val > END_MAX)
                rend_val = END_MAX;

            send_word(fn, idx, END_W'(rend_val));
        end
    endtask

    // Clear a heavily loaded tree and check that it starts over from empty.
    task automatic test_clear_after_load();
        bit [INDEX_W-1:0] idx;
        idx = INDEX_W'($urandom_range(0, NUM_LEAVES - 1));
        send_word(FN_RANGE,  17'd0, 18'd131072);
        send_word(FN_CLEAR,  idx,   18'd0);
        send_word(FN_RANGE,  17'd0, 18'h3FFFF);
        send_word(FN_SUFFIX, idx,   18'd0);
        send_word(FN_SUFFIX, idx,   18'd0);
        send_word(FN_RANGE,  idx,   END_W'(idx) + 18'd1);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_random_mix(1330);
        test_clear_after_load();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), '0);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
